FILE: sv/indexed_deque_engine_core_defines.svh
// assertion macros for the indexed deque engine
// no dependencies
`ifndef INDEXED_DEQUE_ENGINE_CORE_DEFINES_SVH
`define INDEXED_DEQUE_ENGINE_CORE_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define IDQ_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define IDQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: sv/idq_pkg.sv
// shared types and constants of the indexed deque engine
// no dependencies
package idq_pkg;
    localparam int CapacityDef  = 64;
    localparam int DataWidthDef = 32;

    typedef enum logic [3:0] {
        CMD_PUSH     = 4'd0,
        CMD_APPEND   = 4'd1,
        CMD_POP      = 4'd2,
        CMD_DROP     = 4'd3,
        CMD_GET      = 4'd4,
        CMD_REMOVE   = 4'd5,
        CMD_FIND_F   = 4'd6,
        CMD_FIND_L   = 4'd7,
        CMD_RM_F     = 4'd8,
        CMD_RM_L     = 4'd9,
        CMD_RM_ALL   = 4'd10,
        CMD_SWAP     = 4'd11,
        CMD_CLEAR    = 4'd12
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_BADIDX   = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RD,
        S_RDWAIT,
        S_STEP,
        S_SWAP2,
        S_DONE
    } state_t;

    localparam logic [6:0] POS_NONE = 7'h7f;
endpackage

FILE: sv/idq_store.sv
// circular data store, one write and one registered read per cycle
// depends on idq_pkg
module idq_store #(
    parameter int CAPACITY   = idq_pkg::CapacityDef,
    parameter int DATA_WIDTH = idq_pkg::DataWidthDef,
    localparam int AW = $clog2(CAPACITY)
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic [AW-1:0]         rd_addr,
    output logic [DATA_WIDTH-1:0] rd_data
);
    logic [DATA_WIDTH-1:0] mem [CAPACITY];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

FILE: sv/indexed_deque_engine_core.sv
// indexed deque engine top level: command sequencer around one data store
// depends on idq_pkg, idq_store and indexed_deque_engine_core_defines.svh
//
// usage
//   input channel s_*: one command transaction (kind, value, index_a, index_b)
//   result channel m_*: exactly one result transaction per command
//   s_ready is high only when the sequencer is idle and no result is pending;
//   one command is in flight at a time
//   push, append, clear and the error cases finish in S_DECODE and go
//   straight to S_DONE; pop, drop and get add one store read (S_RD,
//   S_RDWAIT); swap reads both entries and writes them back in S_SWAP2
//   and S_DONE; searches and removals walk the list one entry at a time,
//   a read through S_RD and S_RDWAIT per entry visited, set by the single
//   read port of the store; the next command is taken the cycle after the
//   result transaction; the result is held in m_* registers until m_ready,
//   and the sequencer waits there, so a stalled receiver stalls the input
//   reset clears head slot, count and control; store contents are not
//   cleared and are only ever read after being written
`include "indexed_deque_engine_core_defines.svh"
module indexed_deque_engine_core #(
    parameter int CAPACITY   = idq_pkg::CapacityDef,
    parameter int DATA_WIDTH = idq_pkg::DataWidthDef
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_kind,
    input  logic [31:0] s_value,
    input  logic [5:0]  s_index_a,
    input  logic [5:0]  s_index_b,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_data_out,
    output logic signed [6:0] m_position,
    output logic [2:0]  m_status,
    output logic [6:0]  m_fill
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    idq_pkg::state_t state_reg, state_next;
    logic [3:0]            kind_reg, kind_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic [CW-1:0]         ia_reg, ia_next, ib_reg, ib_next;
    logic [AW-1:0]         head_reg, head_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    // walk index (read side) and keep index (write side)
    logic [CW-1:0]         k_reg, k_next, keep_reg, keep_next;
    logic                  found_reg, found_next;
    logic [DATA_WIDTH-1:0] hold_reg, hold_next;
    logic [DATA_WIDTH-1:0] data_reg, data_next;
    logic [6:0]            pos_reg, pos_next;
    logic [2:0]            st_reg, st_next;
    logic                  mv_reg, mv_next;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr, rd_addr;
    logic [DATA_WIDTH-1:0] wr_data, rd_data;
    logic [CW-1:0]         slot_idx;
    logic [AW-1:0]         slot_sel;
    logic                  match;

    idq_store #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // list index to store slot, an adder with a wrap compare, used for slot_sel and for the pop head advance
    function automatic logic [AW-1:0] slot_f(input logic [AW-1:0] h,
                                             input logic [CW-1:0] i);
        logic [CW:0] s;
        s = (CW+1)'(h) + (CW+1)'(i);
        if (s >= (CW+1)'(CAPACITY)) begin
            s = s - (CW+1)'(CAPACITY);
        end
        return s[AW-1:0];
    endfunction

    assign slot_sel = slot_f(head_reg, slot_idx);
    assign match    = (rd_data == val_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= idq_pkg::S_IDLE;
            head_reg  <= '0;
            cnt_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            cnt_reg   <= cnt_next;
            mv_reg    <= mv_next;
        end
        kind_reg  <= kind_next;
        val_reg   <= val_next;
        ia_reg    <= ia_next;
        ib_reg    <= ib_next;
        k_reg     <= k_next;
        keep_reg  <= keep_next;
        found_reg <= found_next;
        hold_reg  <= hold_next;
        data_reg  <= data_next;
        pos_reg   <= pos_next;
        st_reg    <= st_next;
    end

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        val_next   = val_reg;
        ia_next    = ia_reg;
        ib_next    = ib_reg;
        head_next  = head_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        keep_next  = keep_reg;
        found_next = found_reg;
        hold_next  = hold_reg;
        data_next  = data_reg;
        pos_next   = pos_reg;
        st_next    = st_reg;
        mv_next    = mv_reg;
        wr_en      = 1'b0;
        wr_addr    = slot_sel;
        wr_data    = val_reg;
        slot_idx   = k_reg;
        rd_addr    = slot_sel;
        s_ready    = 1'b0;

        case (state_reg)
            idq_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    kind_next  = s_kind;
                    val_next   = DATA_WIDTH'(s_value);
                    ia_next    = CW'(s_index_a);
                    ib_next    = CW'(s_index_b);
                    data_next  = '0;
                    pos_next   = idq_pkg::POS_NONE;
                    st_next    = idq_pkg::ST_OK;
                    found_next = 1'b0;
                    state_next = idq_pkg::S_DECODE;
                end
            end
            idq_pkg::S_DECODE: begin
                state_next = idq_pkg::S_DONE;
                case (kind_reg)
                    idq_pkg::CMD_PUSH, idq_pkg::CMD_APPEND: begin
                        if (cnt_reg >= CAP_C) begin
                            st_next = idq_pkg::ST_FULL;
                        end else if (kind_reg == idq_pkg::CMD_PUSH) begin
                            slot_idx  = CAP_C - CW'(1);
                            wr_en     = 1'b1;
                            head_next = slot_sel;
                            cnt_next  = cnt_reg + CW'(1);
                        end else begin
                            slot_idx = cnt_reg;
                            wr_en    = 1'b1;
                            cnt_next = cnt_reg + CW'(1);
                        end
                    end
                    idq_pkg::CMD_POP, idq_pkg::CMD_DROP: begin
                        if (cnt_reg == '0) begin
                            st_next = idq_pkg::ST_EMPTY;
                        end else begin
                            k_next     = (kind_reg == idq_pkg::CMD_POP) ? '0
                                                                        : cnt_reg - CW'(1);
                            state_next = idq_pkg::S_RD;
                        end
                    end
                    idq_pkg::CMD_GET, idq_pkg::CMD_REMOVE, idq_pkg::CMD_SWAP: begin
                        if (cnt_reg == '0) begin
                            st_next = idq_pkg::ST_EMPTY;
                        end else if (ia_reg >= cnt_reg ||
                                     (kind_reg == idq_pkg::CMD_SWAP && ib_reg >= cnt_reg)) begin
                            st_next = idq_pkg::ST_BADIDX;
                        end else begin
                            k_next     = ia_reg;
                            state_next = idq_pkg::S_RD;
                        end
                    end
                    idq_pkg::CMD_FIND_F, idq_pkg::CMD_FIND_L, idq_pkg::CMD_RM_F,
                    idq_pkg::CMD_RM_L, idq_pkg::CMD_RM_ALL: begin
                        if (cnt_reg == '0) begin
                            st_next = idq_pkg::ST_NOTFOUND;
                        end else begin
                            k_next     = (kind_reg == idq_pkg::CMD_FIND_L ||
                                          kind_reg == idq_pkg::CMD_RM_L) ? cnt_reg - CW'(1)
                                                                         : '0;
                            keep_next  = '0;
                            state_next = idq_pkg::S_RD;
                        end
                    end
                    idq_pkg::CMD_CLEAR: begin
                        cnt_next  = '0;
                        head_next = '0;
                    end
                    default: ;
                endcase
            end
            idq_pkg::S_RD: begin
                // address presented, data back next cycle
                state_next = idq_pkg::S_RDWAIT;
            end
            idq_pkg::S_RDWAIT: begin
                state_next = idq_pkg::S_DONE;
                case (kind_reg)
                    idq_pkg::CMD_POP: begin
                        data_next = rd_data;
                        head_next = slot_f(head_reg, CW'(1));
                        cnt_next  = cnt_reg - CW'(1);
                    end
                    idq_pkg::CMD_DROP: begin
                        data_next = rd_data;
                        cnt_next  = cnt_reg - CW'(1);
                    end
                    idq_pkg::CMD_GET: begin
                        data_next = rd_data;
                    end
                    idq_pkg::CMD_SWAP: begin
                        // first word kept, fetch the second
                        hold_next  = rd_data;
                        k_next     = ib_reg;
                        state_next = idq_pkg::S_SWAP2;
                    end
                    idq_pkg::CMD_REMOVE: begin
                        data_next  = rd_data;
                        found_next = 1'b1;
                        state_next = idq_pkg::S_STEP;
                    end
                    idq_pkg::CMD_FIND_F, idq_pkg::CMD_RM_F,
                    idq_pkg::CMD_FIND_L, idq_pkg::CMD_RM_L: begin
                        if (match) begin
                            pos_next = 7'(k_reg);
                            if (kind_reg == idq_pkg::CMD_RM_F ||
                                kind_reg == idq_pkg::CMD_RM_L) begin
                                data_next  = rd_data;
                                found_next = 1'b1;
                                state_next = idq_pkg::S_STEP;
                            end
                        end else if ((kind_reg == idq_pkg::CMD_FIND_F ||
                                      kind_reg == idq_pkg::CMD_RM_F) ?
                                     (k_reg + CW'(1) >= cnt_reg) : (k_reg == '0)) begin
                            st_next = idq_pkg::ST_NOTFOUND;
                        end else begin
                            k_next = (kind_reg == idq_pkg::CMD_FIND_F ||
                                      kind_reg == idq_pkg::CMD_RM_F) ? k_reg + CW'(1)
                                                                     : k_reg - CW'(1);
                            state_next = idq_pkg::S_RD;
                        end
                    end
                    idq_pkg::CMD_RM_ALL: begin
                        // compact: write survivors at keep
                        if (!match) begin
                            slot_idx  = keep_reg;
                            wr_en     = 1'b1;
                            wr_data   = rd_data;
                            keep_next = keep_reg + CW'(1);
                        end
                        if (k_reg + CW'(1) >= cnt_reg) begin
                            cnt_next = match ? keep_reg : keep_reg + CW'(1);
                            if ((match ? keep_reg : keep_reg + CW'(1)) == cnt_reg) begin
                                st_next = idq_pkg::ST_NOTFOUND;
                            end
                        end else begin
                            k_next     = k_reg + CW'(1);
                            state_next = idq_pkg::S_RD;
                        end
                    end
                    default: ;
                endcase
            end
            idq_pkg::S_STEP: begin
                // shift entry k+1 into k, one read and one write per pass
                if (found_reg) begin
                    if (k_reg + CW'(1) >= cnt_reg) begin
                        cnt_next   = cnt_reg - CW'(1);
                        state_next = idq_pkg::S_DONE;
                    end else begin
                        slot_idx   = k_reg + CW'(1);
                        found_next = 1'b0;
                    end
                end else begin
                    slot_idx   = k_reg;
                    wr_en      = 1'b1;
                    wr_data    = rd_data;
                    k_next     = k_reg + CW'(1);
                    found_next = 1'b1;
                end
            end
            idq_pkg::S_SWAP2: begin
                // k=ib is presented on the first SWAP2 pass; its data is here on the second
                if (!found_reg) begin
                    found_next = 1'b1;
                end else begin
                    slot_idx   = ib_reg;
                    wr_en      = 1'b1;
                    wr_data    = hold_reg;
                    hold_next  = rd_data;
                    found_next = 1'b0;
                    k_next     = ia_reg;
                    state_next = idq_pkg::S_DONE;
                    kind_next  = 4'(idq_pkg::CMD_SWAP) | 4'd0;
                    pos_next   = idq_pkg::POS_NONE;
                    ib_next    = ia_reg;
                    val_next   = rd_data;
                    st_next    = idq_pkg::ST_OK;
                    data_next  = '0;
                    mv_next    = 1'b0;
                    state_next = idq_pkg::S_DONE;
                    // second write of ia happens in DONE
                    keep_next  = '1;
                end
            end
            idq_pkg::S_DONE: begin
                if (kind_reg == idq_pkg::CMD_SWAP && keep_reg == '1) begin
                    slot_idx  = ia_reg;
                    wr_en     = 1'b1;
                    wr_data   = hold_reg;
                    keep_next = '0;
                end
                if (!mv_reg) begin
                    mv_next = 1'b1;
                end else if (m_ready) begin
                    mv_next    = 1'b0;
                    state_next = idq_pkg::S_IDLE;
                end
            end
            default: state_next = idq_pkg::S_IDLE;
        endcase
    end

    assign m_valid    = mv_reg;
    assign m_data_out = 32'(data_reg);
    assign m_position = pos_reg;
    assign m_status   = st_reg;
    assign m_fill     = 7'(cnt_reg);

    `IDQ_ASSERT_IMP(a_ready_idle, aclk, aresetn, s_ready, !m_valid)
    `IDQ_ASSERT_IMP(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= CAP_C)
    `IDQ_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_valid && s_ready, !s_ready)
    `IDQ_ASSERT_IMP(a_valid_done, aclk, aresetn, m_valid, state_reg == idq_pkg::S_DONE)
endmodule
